### src/shell_token_lexer_top_assert.svh
// Assertion macros shared by the lexer modules.
`ifndef SHELL_TOKEN_LEXER_TOP_ASSERT_SVH
`define SHELL_TOKEN_LEXER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define STL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/stl_pkg.sv
package stl_pkg;

  // Special bytes of the command line.
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_PIPE       = 8'h7C;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // Token kinds.
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_SQ     = 2'd1;
  localparam logic [1:0] KIND_DQ     = 2'd2;
  localparam logic [1:0] KIND_DOLLAR = 2'd3;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       has_byte;
    logic [1:0] kind;
    logic       token_end;
    logic       quote_error;
    logic       line_done;
  } out_item_t;

  // Results caused by one request: first always valid, second when two is set.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } rec_t;

endpackage

### src/stl_front.sv
module stl_front
  import stl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_item_t in_item,
  output logic     rec_push,
  output rec_t     rec_data
);

  `include "shell_token_lexer_top_assert.svh"

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_SQ     = 3'd2,
    MODE_DQ     = 3'd3,
    MODE_DOLLAR = 3'd4,
    MODE_LT     = 3'd5,
    MODE_GT     = 3'd6
  } mode_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
    mode_t     mode;
  } start_t;

  function automatic out_item_t mk_item(input logic [7:0] b, input logic has,
                                        input logic [1:0] k, input logic e,
                                        input logic err, input logic done);
    out_item_t it;
    it.token_byte  = has ? b : 8'd0;
    it.has_byte    = has;
    it.kind        = k;
    it.token_end   = e;
    it.quote_error = err;
    it.line_done   = done;
    return it;
  endfunction

  function automatic logic is_name_byte(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDERSCORE};
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return !(c inside {CH_SPACE, CH_SQUOTE, CH_DQUOTE, CH_DOLLAR, CH_PIPE, CH_LT,
                       CH_GT});
  endfunction

  // Classify a byte seen between tokens.
  function automatic start_t start_token(input logic [7:0] c);
    start_t s;
    s.vld  = 1'b1;
    s.item = mk_item(c, 1'b1, KIND_PLAIN, 1'b0, 1'b0, 1'b0);
    s.mode = MODE_WORD;
    case (c)
      CH_SPACE: begin
        s.vld  = 1'b0;
        s.mode = MODE_IDLE;
      end
      CH_SQUOTE: begin
        s.vld  = 1'b0;
        s.mode = MODE_SQ;
      end
      CH_DQUOTE: begin
        s.vld  = 1'b0;
        s.mode = MODE_DQ;
      end
      CH_DOLLAR: begin
        s.item = mk_item(c, 1'b1, KIND_DOLLAR, 1'b0, 1'b0, 1'b0);
        s.mode = MODE_DOLLAR;
      end
      CH_PIPE: begin
        s.item = mk_item(c, 1'b1, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
        s.mode = MODE_IDLE;
      end
      CH_LT:   s.mode = MODE_LT;
      CH_GT:   s.mode = MODE_GT;
      default: s.mode = MODE_WORD;
    endcase
    return s;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic [1:0] cnt;
  rec_t       rec;
  start_t     st;
  logic [7:0] c;

  assign c  = in_item.ch;
  assign st = start_token(c);

  always_comb begin
    mode_nxt    = mode_r;
    cnt         = 2'd0;
    rec.two     = 1'b0;
    rec.first   = mk_item(8'd0, 1'b0, KIND_PLAIN, 1'b0, 1'b0, 1'b0);
    rec.second  = rec.first;
    if (in_item.end_of_line) begin
      mode_nxt = MODE_IDLE;
      cnt      = 2'd1;
      case (mode_r)
        MODE_WORD, MODE_LT, MODE_GT:
          rec.first = mk_item(8'd0, 1'b0, KIND_PLAIN, 1'b1, 1'b0, 1'b1);
        MODE_DOLLAR:
          rec.first = mk_item(8'd0, 1'b0, KIND_DOLLAR, 1'b1, 1'b0, 1'b1);
        MODE_SQ:
          rec.first = mk_item(8'd0, 1'b0, KIND_SQ, 1'b1, 1'b1, 1'b1);
        MODE_DQ:
          rec.first = mk_item(8'd0, 1'b0, KIND_DQ, 1'b1, 1'b1, 1'b1);
        default:
          rec.first = mk_item(8'd0, 1'b0, KIND_PLAIN, 1'b0, 1'b0, 1'b1);
      endcase
    end else begin
      case (mode_r)
        MODE_WORD: begin
          if (is_word_byte(c)) begin
            cnt       = 2'd1;
            rec.first = mk_item(c, 1'b1, KIND_PLAIN, 1'b0, 1'b0, 1'b0);
          end else begin
            cnt        = st.vld ? 2'd2 : 2'd1;
            rec.first  = mk_item(8'd0, 1'b0, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
            rec.second = st.item;
            mode_nxt   = st.mode;
          end
        end
        MODE_SQ: begin
          cnt = 2'd1;
          if (c == CH_SQUOTE) begin
            rec.first = mk_item(8'd0, 1'b0, KIND_SQ, 1'b1, 1'b0, 1'b0);
            mode_nxt  = MODE_IDLE;
          end else begin
            rec.first = mk_item(c, 1'b1, KIND_SQ, 1'b0, 1'b0, 1'b0);
          end
        end
        MODE_DQ: begin
          cnt = 2'd1;
          if (c == CH_DQUOTE) begin
            rec.first = mk_item(8'd0, 1'b0, KIND_DQ, 1'b1, 1'b0, 1'b0);
            mode_nxt  = MODE_IDLE;
          end else begin
            rec.first = mk_item(c, 1'b1, KIND_DQ, 1'b0, 1'b0, 1'b0);
          end
        end
        MODE_DOLLAR: begin
          if (is_name_byte(c)) begin
            cnt       = 2'd1;
            rec.first = mk_item(c, 1'b1, KIND_DOLLAR, 1'b0, 1'b0, 1'b0);
          end else begin
            cnt        = st.vld ? 2'd2 : 2'd1;
            rec.first  = mk_item(8'd0, 1'b0, KIND_DOLLAR, 1'b1, 1'b0, 1'b0);
            rec.second = st.item;
            mode_nxt   = st.mode;
          end
        end
        MODE_LT, MODE_GT: begin
          if ((mode_r == MODE_LT && c == CH_LT) || (mode_r == MODE_GT && c == CH_GT)) begin
            cnt       = 2'd1;
            rec.first = mk_item(c, 1'b1, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
            mode_nxt  = MODE_IDLE;
          end else begin
            cnt        = st.vld ? 2'd2 : 2'd1;
            rec.first  = mk_item(8'd0, 1'b0, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
            rec.second = st.item;
            mode_nxt   = st.mode;
          end
        end
        default: begin
          // Between tokens, and the unused mode code.
          cnt       = st.vld ? 2'd1 : 2'd0;
          rec.first = st.item;
          mode_nxt  = st.mode;
        end
      endcase
    end
    rec.two = (cnt == 2'd2);
  end

  assign rec_push = in_fire && (cnt != 2'd0);
  assign rec_data = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
    end
  end

  // A two-result record always starts by closing the old token.
  `STL_ASSERT_SAME(a_two_closes_first, rec_push && rec_data.two,
    rec_data.first.token_end && !rec_data.first.has_byte,
    "two-result record does not close a token first")

endmodule

### src/stl_queue.sv
module stl_queue
  import stl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  rec_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output logic q_vld,
  output rec_t q_rdata
);

  `include "shell_token_lexer_top_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_vld   = (count_r != '0);
  assign q_rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  `STL_ASSERT_SAME(a_no_overflow, q_push, !q_full || q_pop,
    "record pushed into a full queue")
  `STL_ASSERT_SAME(a_no_underflow, q_pop, q_vld, "record popped from an empty queue")

endmodule

### src/stl_back.sv
module stl_back
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_vld,
  input  rec_t      q_rdata,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  `include "shell_token_lexer_top_assert.svh"

  rec_t      rec_r, rec_nxt;
  logic      rec_vld_r, rec_vld_nxt;
  logic      idx_r, idx_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      out_vld_r, out_vld_nxt;
  logic      load;
  logic      last;

  // Output register is free, or its result leaves this cycle.
  assign load  = !out_vld_r || pop;
  assign last  = !rec_r.two || idx_r;
  assign q_pop = q_vld && (!rec_vld_r || (load && last));

  always_comb begin
    rec_nxt      = rec_r;
    rec_vld_nxt  = rec_vld_r;
    idx_nxt      = idx_r;
    out_item_nxt = out_item_r;
    out_vld_nxt  = out_vld_r;
    if (load) begin
      out_vld_nxt = rec_vld_r;
      if (rec_vld_r) begin
        out_item_nxt = idx_r ? rec_r.second : rec_r.first;
        if (last) begin
          rec_vld_nxt = 1'b0;
          idx_nxt     = 1'b0;
        end else begin
          idx_nxt = 1'b1;
        end
      end
    end
    if (q_pop) begin
      rec_nxt     = q_rdata;
      rec_vld_nxt = 1'b1;
      idx_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_vld_r <= 1'b0;
      idx_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rec_vld_r <= rec_vld_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r      <= rec_nxt;
    out_item_r <= out_item_nxt;
  end

  assign empty    = !out_vld_r;
  assign out_data = out_item_r;

  `STL_ASSERT_SAME(a_second_needs_two, idx_r, rec_vld_r && rec_r.two,
    "second result selected from a one-result record")
  `STL_ASSERT_NEXT(a_pop_loads_record, q_pop, rec_vld_r && !idx_r,
    "popped record not held")

endmodule

### src/shell_token_lexer_top.sv
// Shell command-line lexer. Push one byte of the command line per request,
// then a request with end_of_line set; pop the token stream from the other
// side. Each result carries at most one token byte, the kind of the token
// it belongs to (word or operator, single-quoted, double-quoted, dollar
// name), and token_end on the result that closes the token. Quotes are
// dropped, so empty quotes give a token with token_end and no bytes. A
// quote left open at end of line closes its token with quote_error set:
// drop that token. line_done marks the one result of the end-of-line
// request. A request causes zero, one or two results; two when a byte both
// closes one token and starts another. Rate: requests are taken one per
// cycle while the record queue has room, and results leave one per cycle
// while pop is held, so bytes that each make one result run at one request
// per cycle, and a two-result request sends its two results in turn; the
// single result register of the back end sets that bound. The first result
// of a request passes the record queue, the record register and the output
// register of the back end. full reflects only the record queue (depth
// QUEUE_DEPTH_P), so requests keep flowing while a result waits to be popped.
module shell_token_lexer_top
  import stl_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  // request side
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  // result side
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic in_fire;
  logic rec_push;
  rec_t rec_data;
  logic q_full;
  logic q_vld;
  logic q_pop;
  rec_t q_rdata;

  // Accept a request whenever the queue has room.
  assign full    = q_full;
  assign in_fire = push && !q_full;

  // Front: track the lexer mode and turn each byte into a record of results.
  stl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .rec_push (rec_push),
    .rec_data (rec_data)
  );

  // Hold records between classification and output.
  stl_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (rec_push),
    .q_wdata (rec_data),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_vld   (q_vld),
    .q_rdata (q_rdata)
  );

  // Back: split each record into single results and drive the output register.
  stl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

### bench/stl_token_checker.sv
`timescale 1ns / 100ps
module stl_token_checker
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_data,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_data,
  output int        miss_cnt,
  output int        tokens_pending
);

  typedef enum logic [2:0] {
    LX_IDLE, LX_WORD, LX_SQ, LX_DQ, LX_NAME, LX_LT, LX_GT
  } lex_mode_e;

  lex_mode_e lex_mode;
  out_item_t tokens_due[$];

  function automatic bit is_name_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == CH_UNDERSCORE;
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return c != CH_SPACE && c != CH_SQUOTE && c != CH_DQUOTE && c != CH_DOLLAR &&
           c != CH_PIPE && c != CH_LT && c != CH_GT;
  endfunction

  function automatic string fmt_token(out_item_t t);
    return $sformatf("byte %02h has %0d kind %0d end %0d err %0d done %0d",
                     t.token_byte, t.has_byte, t.kind, t.token_end,
                     t.quote_error, t.line_done);
  endfunction

  task automatic emit(logic [7:0] b, bit has, logic [1:0] k, bit fin, bit err,
                      bit done);
    out_item_t r;
    r.token_byte  = has ? b : 8'h00;
    r.has_byte    = has;
    r.kind        = k;
    r.token_end   = fin;
    r.quote_error = err;
    r.line_done   = done;
    tokens_due.push_back(r);
  endtask

  // Byte seen between tokens.
  task automatic open_token(logic [7:0] c);
    lex_mode = LX_IDLE;
    case (c)
      CH_SPACE: ;
      CH_SQUOTE: lex_mode = LX_SQ;
      CH_DQUOTE: lex_mode = LX_DQ;
      CH_DOLLAR: begin
        lex_mode = LX_NAME;
        emit(c, 1'b1, KIND_DOLLAR, 1'b0, 1'b0, 1'b0);
      end
      CH_PIPE: emit(c, 1'b1, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
      CH_LT: begin
        lex_mode = LX_LT;
        emit(c, 1'b1, KIND_PLAIN, 1'b0, 1'b0, 1'b0);
      end
      CH_GT: begin
        lex_mode = LX_GT;
        emit(c, 1'b1, KIND_PLAIN, 1'b0, 1'b0, 1'b0);
      end
      default: begin
        lex_mode = LX_WORD;
        emit(c, 1'b1, KIND_PLAIN, 1'b0, 1'b0, 1'b0);
      end
    endcase
  endtask

  task automatic lex_request(in_item_t req);
    logic [7:0] c;
    c = req.ch;
    if (req.end_of_line) begin
      case (lex_mode)
        LX_WORD, LX_LT, LX_GT: emit(8'h00, 1'b0, KIND_PLAIN, 1'b1, 1'b0, 1'b1);
        LX_NAME: emit(8'h00, 1'b0, KIND_DOLLAR, 1'b1, 1'b0, 1'b1);
        LX_SQ:   emit(8'h00, 1'b0, KIND_SQ, 1'b1, 1'b1, 1'b1);
        LX_DQ:   emit(8'h00, 1'b0, KIND_DQ, 1'b1, 1'b1, 1'b1);
        default: emit(8'h00, 1'b0, KIND_PLAIN, 1'b0, 1'b0, 1'b1);
      endcase
      lex_mode = LX_IDLE;
    end else begin
      case (lex_mode)
        LX_WORD: begin
          if (is_word_char(c)) begin
            emit(c, 1'b1, KIND_PLAIN, 1'b0, 1'b0, 1'b0);
          end else begin
            emit(8'h00, 1'b0, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
            open_token(c);
          end
        end
        LX_SQ: begin
          if (c == CH_SQUOTE) begin
            lex_mode = LX_IDLE;
            emit(8'h00, 1'b0, KIND_SQ, 1'b1, 1'b0, 1'b0);
          end else begin
            emit(c, 1'b1, KIND_SQ, 1'b0, 1'b0, 1'b0);
          end
        end
        LX_DQ: begin
          if (c == CH_DQUOTE) begin
            lex_mode = LX_IDLE;
            emit(8'h00, 1'b0, KIND_DQ, 1'b1, 1'b0, 1'b0);
          end else begin
            emit(c, 1'b1, KIND_DQ, 1'b0, 1'b0, 1'b0);
          end
        end
        LX_NAME: begin
          if (is_name_char(c)) begin
            emit(c, 1'b1, KIND_DOLLAR, 1'b0, 1'b0, 1'b0);
          end else begin
            emit(8'h00, 1'b0, KIND_DOLLAR, 1'b1, 1'b0, 1'b0);
            open_token(c);
          end
        end
        LX_LT, LX_GT: begin
          if ((lex_mode == LX_LT && c == CH_LT) || (lex_mode == LX_GT && c == CH_GT)) begin
            lex_mode = LX_IDLE;
            emit(c, 1'b1, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
          end else begin
            emit(8'h00, 1'b0, KIND_PLAIN, 1'b1, 1'b0, 1'b0);
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      lex_mode = LX_IDLE;
      tokens_due.delete();
      miss_cnt <= 0;
    end else begin
      if (push && !full) lex_request(in_data);
      if (pop && !empty) begin
        if (tokens_due.size() == 0) begin
          if (miss_cnt < 10)
            $display("%0t unexpected token result: %s", $time, fmt_token(out_data));
          miss_cnt <= miss_cnt + 1;
        end else begin
          want = tokens_due.pop_front();
          if (want !== out_data) begin
            if (miss_cnt < 10)
              $display("%0t token result differs: expected %s, got %s", $time,
                       fmt_token(want), fmt_token(out_data));
            miss_cnt <= miss_cnt + 1;
          end
        end
      end
    end
    tokens_pending <= tokens_due.size();
  end

endmodule

### bench/tb_shell_token_lexer_top.sv
`timescale 1ns / 100ps
module tb_shell_token_lexer_top;
  import stl_pkg::*;

  localparam int RANDOM_REQS  = 450;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data;

  int miss_cnt;
  int tokens_pending;
  int sent_cnt = 0;
  int cycle_cnt = 0;
  int pop_idle = 0;
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit rx_hold = 1'b0;

  string ops[5] = '{"|", "<", "<<", ">", ">>"};
  string name_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  always #2 clk = ~clk;

  shell_token_lexer_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  stl_token_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .empty          (empty),
    .pop            (pop),
    .out_data       (out_data),
    .miss_cnt       (miss_cnt),
    .tokens_pending (tokens_pending)
  );

  // Abort a hung run: the slowest legal run is far below this many cycles.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("shell_token_lexer_top: mismatch");
      $finish;
    end
  end

  // Result side: after each popped result, idle for a random gap, except in eager
  // stretches where pop stays high. Drop pop entirely while rx_hold is set.
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      pop <= 1'b0;
      pop_idle <= 0;
    end else if (rx_hold) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      if ($urandom_range(0, 31) == 0) rx_eager = !rx_eager;
      gap = rx_eager ? 0 : $urandom_range(0, 3);
      pop <= (gap == 0);
      pop_idle <= gap;
    end else if (!pop) begin
      if (pop_idle <= 1) begin
        pop <= 1'b1;
        pop_idle <= 0;
      end else begin
        pop_idle <= pop_idle - 1;
      end
    end
  end

  // Long back-pressure: hold the result side off while requests keep coming,
  // so the record queue fills and full stalls the sender.
  initial begin
    wait (sent_cnt >= 140);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Offer one request after a random gap and hold it until accepted.
  // push stays high on return so back-to-back requests need no extra edge.
  task automatic send_req(input logic [7:0] c, input bit eol);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= '{ch: c, end_of_line: eol};
    @(posedge clk);
    while (full) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
  endtask

  // Terminate a line; the byte that rides along with end_of_line is ignored.
  task automatic send_eol();
    send_req(8'($urandom_range(1, 255)), 1'b1);
  endtask

  // Stop offering and wait until every predicted result has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    wait (tokens_pending == 0);
    @(posedge clk);
  endtask

  // Mostly well-formed command lines with random content; some lines are raw
  // byte noise with stray end-of-line marks, and a few quotes are left open.
  task automatic send_line();
    int         n_tok;
    int         pick;
    logic [7:0] c;
    logic [7:0] quote;
    tx_eager = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 12))
        send_req(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
    end else begin
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
        // zero spaces lets tokens butt against each other
        repeat ($urandom_range(0, 2)) send_req(CH_SPACE, 1'b0);
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2: begin
            repeat ($urandom_range(1, 5)) begin
              c = CH_SPACE;
              while (c == CH_SPACE || c == CH_SQUOTE || c == CH_DQUOTE ||
                     c == CH_DOLLAR || c == CH_PIPE || c == CH_LT || c == CH_GT)
                c = 8'($urandom_range(1, 255));
              send_req(c, 1'b0);
            end
          end
          3, 4: begin
            quote = (pick == 3) ? CH_SQUOTE : CH_DQUOTE;
            send_req(quote, 1'b0);
            repeat ($urandom_range(0, 4)) begin
              c = quote;
              while (c == quote) c = 8'($urandom_range(1, 255));
              send_req(c, 1'b0);
            end
            // leave the quote open now and then
            if ($urandom_range(0, 9) != 0) send_req(quote, 1'b0);
          end
          5: begin
            send_req(CH_DOLLAR, 1'b0);
            repeat ($urandom_range(0, 4))
              send_req(name_set[$urandom_range(0, name_set.len() - 1)], 1'b0);
          end
          6, 7: send_text(ops[$urandom_range(0, 4)]);
          default: send_req(8'($urandom_range(1, 255)), 1'b0);
        endcase
      end
      send_eol();
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    // Hold reset low from the start, then release it for good.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // Empty line: bare line_done.
    send_eol();
    // Word with a high byte and a zero byte, closed by a pipe; then the
    // doubled operators, with a triple '<' and triple '>' leaving a single
    // '>' pending at end of line.
    send_req("a", 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b0);
    send_text("|<<<>>>");
    send_eol();
    // Dollar name ended by a second dollar, lone dollar ended by a space,
    // empty single quotes, and a double quote still open at end of line.
    send_text("$_Z9$ ''\"x");
    send_eol();
    // Single quote still open at end of line.
    send_text("'q");
    send_eol();
    drain_results();

    // Random part, with one full drain partway through.
    while (sent_cnt < RANDOM_REQS + 26) begin
      send_line();
      if (!paused && sent_cnt >= 300) begin
        drain_results();
        paused = 1'b1;
      end
    end
    push <= 1'b0;
    @(posedge clk);
    wait (tokens_pending == 0);
    // Let any late, unexpected result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (miss_cnt == 0) begin
      $display("shell_token_lexer_top: match");
    end else begin
      $display("shell_token_lexer_top: mismatch");
    end
    $finish;
  end

endmodule
